FILE: design/mpfc_pkg.sv
// ---------------------------------------------------------------------------
// mpfc_pkg
// Shared types and constants for the Mobius and prime factor count block.
// ---------------------------------------------------------------------------
package mpfc_pkg;

   // Result field widths and codes.
   localparam int COUNT_WIDTH    = 5;
   localparam int SIGN_WIDTH     = 2;
   localparam int RSP_DATA_WIDTH = 16;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = 5'd31;
   localparam logic [SIGN_WIDTH-1:0]  SIGN_PLUS    = 2'b01;
   localparam logic [SIGN_WIDTH-1:0]  SIGN_ZERO    = 2'b00;
   localparam logic [SIGN_WIDTH-1:0]  SIGN_MINUS   = 2'b11;

   // First trial divisor.
   localparam int FIRST_DIVISOR = 2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_TAIL,
      ST_EMIT
   } mpfc_state_type;

   // Sequencer to divider.
   typedef struct packed {
      logic start;
   } mpfc_div_ctrl_type;

   // Divider to sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } mpfc_div_stat_type;

endpackage

FILE: design/mpfc_divider.sv
// ---------------------------------------------------------------------------
// mpfc_divider
// Radix-2 restoring divider, one quotient bit per cycle, giving quotient
// and remainder of a dividend by a narrower divisor.
// ---------------------------------------------------------------------------
module mpfc_divider
   import mpfc_pkg::*;
#(
   parameter int NUMBER_WIDTH  = 32,
   parameter int DIVISOR_WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mpfc_div_ctrl_type        ctrl,
   input  logic [NUMBER_WIDTH-1:0]  dividend,
   input  logic [DIVISOR_WIDTH-1:0] divisor,
   output mpfc_div_stat_type        stat,
   output logic [NUMBER_WIDTH-1:0]  quotient,
   output logic [DIVISOR_WIDTH-1:0] remainder
);

   localparam int CW = $clog2(NUMBER_WIDTH);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [NUMBER_WIDTH-1:0]  quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] dvs_ff, dvs_in;

   logic [DIVISOR_WIDTH:0]   trial;
   logic [DIVISOR_WIDTH:0]   diff;
   logic                     fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
      fits  = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUMBER_WIDTH - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // A remainder is always below the divisor, so it fits its width.
         rem_in = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         quo_in = {quo_ff[NUMBER_WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: design/mobius_and_prime_factor_count.sv
// ---------------------------------------------------------------------------
// Each value is classified by a sequence of trial divisions in the shared
// divider, plus set-up and wind-down. A 32-bit prime walks about 65535
// divisors; small or smooth values need far fewer.
// One value is worked on at a time; the next is taken once the result has
// been loaded into the output register. Reset is synchronous and active high
// and returns the sequencer, divider and output register to empty.
// ---------------------------------------------------------------------------
// mobius_and_prime_factor_count
// Classifies one unsigned value by trial division, returning the Mobius
// value, the prime factor count with multiplicity and the Liouville value.
// ---------------------------------------------------------------------------
module mobius_and_prime_factor_count
   import mpfc_pkg::*;
#(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input beats.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: number [NUMBER_WIDTH-1:0], zero padding above.
   input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]     req_tdata,
   // Result beats.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: mobius [1:0], factor_count [6:2], liouville [8:7], zeros above.
   output logic [RSP_DATA_WIDTH-1:0]             rsp_tdata
);

   // The trial divisor never passes floor(sqrt(2^NUMBER_WIDTH - 1)) + 1, so
   // it needs about half the width of the number plus one bit.
   localparam int DW = (NUMBER_WIDTH + 1) / 2 + 1;

   mpfc_state_type            state_ff, state_in;
   logic [NUMBER_WIDTH-1:0]   rest_ff, rest_in;      // unfactored part
   logic [DW-1:0]             p_ff, p_in;            // trial divisor
   logic                      inner_ff, inner_in;    // dividing out a found prime
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;    // saturating factor count
   logic                      cpar_ff, cpar_in;      // parity of the true count
   logic                      dpar_ff, dpar_in;      // parity of distinct primes
   logic                      sqf_ff, sqf_in;        // still squarefree

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   mpfc_div_ctrl_type         div_ctrl;
   mpfc_div_stat_type         div_stat;
   logic [NUMBER_WIDTH-1:0]   div_quo;
   logic [DW-1:0]             div_rem;

   logic [COUNT_WIDTH-1:0]    count_inc;
   logic                      quo_below_p;
   logic                      rem_zero;
   logic [SIGN_WIDTH-1:0]     mobius_code;
   logic [SIGN_WIDTH-1:0]     liouville_code;

   mpfc_divider #(
      .NUMBER_WIDTH  (NUMBER_WIDTH),
      .DIVISOR_WIDTH (DW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (rest_ff),
      .divisor   (p_ff),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      count_inc   = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      // The loop goes on while p <= rest / p, that is while the quotient
      // is not below the divisor.
      quo_below_p = div_quo < {{(NUMBER_WIDTH-DW){1'b0}}, p_ff};
      rem_zero    = div_rem == '0;

      if (!sqf_ff) begin
         mobius_code = SIGN_ZERO;
      end else begin
         mobius_code = dpar_ff ? SIGN_MINUS : SIGN_PLUS;
      end
      liouville_code = cpar_ff ? SIGN_MINUS : SIGN_PLUS;

      state_in      = state_ff;
      rest_in       = rest_ff;
      p_in          = p_ff;
      inner_in      = inner_ff;
      count_in      = count_ff;
      cpar_in       = cpar_ff;
      dpar_in       = dpar_ff;
      sqf_in        = sqf_ff;
      div_ctrl      = '0;
      req_tready    = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rest_in  = req_tdata[NUMBER_WIDTH-1:0];
               p_in     = DW'(FIRST_DIVISOR);
               inner_in = 1'b0;
               count_in = '0;
               cpar_in  = 1'b0;
               dpar_in  = 1'b0;
               sqf_in   = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            div_ctrl.start = 1'b1;
            state_in       = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               if (!inner_ff) begin
                  if (quo_below_p) begin
                     state_in = ST_TAIL;
                  end else if (rem_zero) begin
                     // A new prime: take it out once and keep dividing by it.
                     rest_in  = div_quo;
                     count_in = count_inc;
                     cpar_in  = !cpar_ff;
                     dpar_in  = !dpar_ff;
                     inner_in = 1'b1;
                     state_in = ST_START;
                  end else begin
                     p_in     = p_ff + 1'b1;
                     state_in = ST_START;
                  end
               end else begin
                  if (rem_zero) begin
                     // The same prime divides again, so n is not squarefree.
                     rest_in  = div_quo;
                     count_in = count_inc;
                     cpar_in  = !cpar_ff;
                     sqf_in   = 1'b0;
                     state_in = ST_START;
                  end else begin
                     p_in     = p_ff + 1'b1;
                     inner_in = 1'b0;
                     state_in = ST_START;
                  end
               end
            end
         end
         ST_TAIL: begin
            // Whatever is left above one is a single prime factor.
            if (rest_ff > NUMBER_WIDTH'(1)) begin
               count_in = count_inc;
               cpar_in  = !cpar_ff;
               dpar_in  = !dpar_ff;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Load the output register once its previous beat has gone.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_WIDTH-9){1'b0}},
                               liouville_code, count_ff, mobius_code};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rest_ff     <= rest_in;
      p_ff        <= p_in;
      inner_ff    <= inner_in;
      count_ff    <= count_in;
      cpar_ff     <= cpar_in;
      dpar_ff     <= dpar_in;
      sqf_ff      <= sqf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The divider is never running while a new value can be taken.
   a_idle_no_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_stat.busy)
      else $error("divider busy while block accepts a value");

   // A finished division is only ever seen by the state that waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_WAIT)
      else $error("division finished outside the wait state");

   // A division is only started with a trial divisor of at least two.
   a_divisor_floor: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> p_ff >= DW'(FIRST_DIVISOR))
      else $error("trial divisor below the first divisor");

   // A zero Mobius value always goes with at least two counted factors.
   a_mobius_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == SIGN_ZERO) |-> rsp_tdata[6:2] >= 5'd2)
      else $error("non-squarefree result with fewer than two factors");

endmodule
